@@ hw/rtl/lge_pkg.sv @@
package lge_pkg;

	// fixed widths of the row and configuration words
	localparam int ROW_W         = 64;
	localparam int GW_W          = 7;
	localparam int MAX_WIDTH_DEF = 64;

	// neighbor count per cell and B3/S23 rule
	localparam int NBR_N = 8;
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] BIRTH_CNT   = CNT_W'(3);
	localparam logic [CNT_W-1:0] SURVIVE_CNT = CNT_W'(2);

	localparam logic [GW_W-1:0] GRID_WIDTH_RST = GW_W'(64);

	// side flags that travel with each result word
	typedef struct packed {
		logic last_in_run;
		logic frame_end;
	} lge_flags_t;

endpackage

@@ hw/rtl/lge_lane.sv @@
module lge_lane (
	input  logic                       self_cell,
	input  logic [lge_pkg::NBR_N-1:0]  nbrs,
	output logic                       alive
);
	import lge_pkg::*;

	logic [CNT_W-1:0] cnt;

	// count live neighbors
	always_comb begin
		cnt = '0;
		for (int i = 0; i < NBR_N; i++) begin
			cnt = cnt + CNT_W'(nbrs[i]);
		end
	end

	// born on three, survives on two or three
	assign alive = (cnt == BIRTH_CNT) || (self_cell && (cnt == SURVIVE_CNT));

endmodule

@@ hw/rtl/lge_row_array.sv @@
module lge_row_array #(
	parameter int LANES = lge_pkg::MAX_WIDTH_DEF
) (
	input  logic [LANES-1:0] up_row,
	input  logic [LANES-1:0] mid_row,
	input  logic [LANES-1:0] down_row,
	input  logic [LANES-1:0] col_mask,
	output logic [LANES-1:0] next_row
);
	import lge_pkg::*;

	// dead columns on both edges of the grid
	logic [LANES+1:0] up_p;
	logic [LANES+1:0] mid_p;
	logic [LANES+1:0] down_p;
	logic [LANES-1:0] lane_alive;

	assign up_p   = {1'b0, up_row, 1'b0};
	assign mid_p  = {1'b0, mid_row, 1'b0};
	assign down_p = {1'b0, down_row, 1'b0};

	// one lane per column
	for (genvar c = 0; c < LANES; c++) begin : g_lane
		logic [NBR_N-1:0] nbrs;

		assign nbrs = {up_p[c], up_p[c+1], up_p[c+2],
			mid_p[c], mid_p[c+2],
			down_p[c], down_p[c+1], down_p[c+2]};

		lge_lane u_lane (
			.self_cell (mid_p[c+1]),
			.nbrs      (nbrs),
			.alive     (lane_alive[c])
		);
	end

	// merge lanes into the result row, unused columns dead
	assign next_row = lane_alive & col_mask;

endmodule

@@ hw/rtl/life_generation_row_engine_unit.sv @@
// A row's result word is computed when the row below it is accepted and is registered in the output
// register (or the skid stage); the bottom row's own result follows from the tail state.
// Throughput: one row per cycle while row_stall is low; the row flagged last_row holds the input
// in the tail state for its second result word (its two result words share one lane array).
// Reset (arst_n low, asynchronous): frame state cleared, output empty, grid_width = 64.
module life_generation_row_engine_unit #(
	parameter int MAX_WIDTH = lge_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic [lge_pkg::GW_W-1:0]    cfg_data,
	// row input channel
	input  logic                        row_valid,
	output logic                        row_stall,
	input  logic [lge_pkg::ROW_W-1:0]   row_cells,
	input  logic                        last_row,
	// result channel
	output logic                        next_valid,
	input  logic                        next_stall,
	output logic [lge_pkg::ROW_W-1:0]   next_cells,
	output logic                        last_in_run,
	output logic                        frame_end
);
	import lge_pkg::*;

	logic [GW_W-1:0]      grid_width_q;
	logic [MAX_WIDTH-1:0] col_mask;

	logic                 held_q;
	logic                 tail_q;
	logic [MAX_WIDTH-1:0] above_q;
	logic [MAX_WIDTH-1:0] middle_q;

	logic [MAX_WIDTH-1:0] row_m;
	logic [MAX_WIDTH-1:0] calc_row;
	logic                 accept;
	logic                 tail_fire;
	logic                 push;
	lge_flags_t           push_flags;

	logic                 out_valid_q;
	logic [MAX_WIDTH-1:0] out_cells_q;
	lge_flags_t           out_flags_q;
	logic                 skid_valid_q;
	logic [MAX_WIDTH-1:0] skid_cells_q;
	lge_flags_t           skid_flags_q;
	logic                 out_take;

	// width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= GRID_WIDTH_RST;
		end else if (cfg_we) begin
			grid_width_q <= cfg_data;
		end
	end

	// column mask: columns at or past grid_width are dead
	for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_mask
		assign col_mask[c] = (grid_width_q > GW_W'(c));
	end

	assign row_m = row_cells[MAX_WIDTH-1:0] & col_mask;

	// handshake
	assign row_stall = tail_q || skid_valid_q;
	assign accept    = row_valid && !row_stall;
	assign tail_fire = tail_q && !skid_valid_q;
	assign push      = tail_fire || (accept && held_q);

	always_comb begin
		if (tail_q) begin
			push_flags.last_in_run = 1'b1;
			push_flags.frame_end   = 1'b1;
		end else begin
			push_flags.last_in_run = !last_row;
			push_flags.frame_end   = 1'b0;
		end
	end

	// lane array: row below is dead on the bottom-row pass
	lge_row_array #(
		.LANES (MAX_WIDTH)
	) u_row_array (
		.up_row   (above_q & col_mask),
		.mid_row  (middle_q & col_mask),
		.down_row (tail_q ? '0 : row_m),
		.col_mask (col_mask),
		.next_row (calc_row)
	);

	// row window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			tail_q   <= 1'b0;
			above_q  <= '0;
			middle_q <= '0;
		end else if (tail_fire) begin
			held_q   <= 1'b0;
			tail_q   <= 1'b0;
			above_q  <= '0;
			middle_q <= '0;
		end else if (accept) begin
			held_q   <= 1'b1;
			tail_q   <= last_row;
			above_q  <= middle_q;
			middle_q <= row_m;
		end
	end

	// output register with skid stage
	assign out_take = out_valid_q && !next_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_cells_q <= skid_cells_q;
				out_flags_q <= skid_flags_q;
			end else if (push) begin
				out_cells_q <= calc_row;
				out_flags_q <= push_flags;
			end
		end else if (push) begin
			skid_cells_q <= calc_row;
			skid_flags_q <= push_flags;
		end
	end

	assign next_valid  = out_valid_q;
	assign next_cells  = ROW_W'(out_cells_q);
	assign last_in_run = out_flags_q.last_in_run;
	assign frame_end   = out_flags_q.frame_end;

endmodule

@@ tb/sv/lge_next_row_checker.sv @@
module lge_next_row_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lge_pkg::GW_W-1:0]  cfg_data,
	input  logic                      row_valid,
	input  logic                      row_stall,
	input  logic [lge_pkg::ROW_W-1:0] row_cells,
	input  logic                      last_row,
	input  logic                      next_valid,
	input  logic                      next_stall,
	input  logic [lge_pkg::ROW_W-1:0] next_cells,
	input  logic                      last_in_run,
	input  logic                      frame_end,
	output int                        mismatch_count,
	output int                        words_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	import lge_pkg::*;

	typedef struct packed {
		logic [ROW_W-1:0] cells;
		lge_flags_t       flags;
	} next_word_t;

	// local copy of the frame state and the width register
	logic [GW_W-1:0]  width_reg;
	logic [ROW_W-1:0] prev_row;
	logic [ROW_W-1:0] held_row;
	logic [1:0]       held_count;
	next_word_t       owed_words[$];

	// live columns for a given width, saturating at MAX_WIDTH_DEF
	function automatic logic [ROW_W-1:0] live_columns(input logic [GW_W-1:0] w);
		int n;
		n = (int'(w) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w);
		if (n == 0)
			return '0;
		if (n >= ROW_W)
			return '1;
		return (ROW_W'(1) << n) - ROW_W'(1);
	endfunction

	// B3/S23 on one row, no wrap at either edge
	function automatic logic [ROW_W-1:0] life_gen(input logic [ROW_W-1:0] up,
			input logic [ROW_W-1:0] mid, input logic [ROW_W-1:0] down,
			input logic [ROW_W-1:0] mask);
		logic [ROW_W-1:0] res;
		int nbrs;
		res = '0;
		for (int c = 0; c < ROW_W; c++) begin
			nbrs = int'(up[c]) + int'(down[c]);
			if (c > 0)
				nbrs += int'(up[c-1]) + int'(mid[c-1]) + int'(down[c-1]);
			if (c < ROW_W - 1)
				nbrs += int'(up[c+1]) + int'(mid[c+1]) + int'(down[c+1]);
			if (nbrs == int'(BIRTH_CNT) || (mid[c] && nbrs == int'(SURVIVE_CNT)))
				res[c] = 1'b1;
		end
		return res & mask;
	endfunction

	function automatic next_word_t make_word(input logic [ROW_W-1:0] cells,
			input logic run_done, input logic bottom);
		next_word_t w;
		w.cells = cells;
		w.flags.last_in_run = run_done;
		w.flags.frame_end = bottom;
		return w;
	endfunction

	// append one predicted word to the tail of the queue
	task automatic owe_word(input next_word_t w);
		owed_words = {owed_words, w};
	endtask

	always @(posedge clk or negedge arst_n) begin
		next_word_t exp_w;
		logic [ROW_W-1:0] mask;
		logic [ROW_W-1:0] row;
		if (!arst_n) begin
			width_reg <= GRID_WIDTH_RST;
			prev_row = '0;
			held_row = '0;
			held_count = '0;
			owed_words.delete();
			mismatch_count <= 0;
			words_owed <= 0;
		end else begin
			// result side: compare against oldest owed word
			if (next_valid && !next_stall) begin
				if (owed_words.size() == 0) begin
					$display("%0t word expected none actual next_cells %h last_in_run %b frame_end %b",
						$time, next_cells, last_in_run, frame_end);
					mismatch_count <= mismatch_count + 1;
				end else begin
					exp_w = owed_words.pop_front();
					if (next_cells !== exp_w.cells ||
							last_in_run !== exp_w.flags.last_in_run ||
							frame_end !== exp_w.flags.frame_end)
						mismatch_count <= mismatch_count + 1;
					if (next_cells !== exp_w.cells)
						$display("%0t next_cells expected %h actual %h",
							$time, exp_w.cells, next_cells);
					if (last_in_run !== exp_w.flags.last_in_run)
						$display("%0t last_in_run expected %b actual %b",
							$time, exp_w.flags.last_in_run, last_in_run);
					if (frame_end !== exp_w.flags.frame_end)
						$display("%0t frame_end expected %b actual %b",
							$time, exp_w.flags.frame_end, frame_end);
				end
			end

			// row side: advance the predicted frame
			if (row_valid && !row_stall) begin
				mask = live_columns(width_reg);
				row = row_cells & mask;
				if (held_count == 2'd0) begin
					if (last_row) begin
						// single-row grid
						owe_word(make_word(life_gen('0, row, '0, mask), 1'b1, 1'b1));
					end else begin
						prev_row = '0;
						held_row = row;
						held_count = 2'd1;
					end
				end else begin
					owe_word(make_word(
						life_gen(prev_row & mask, held_row & mask, row, mask), !last_row, 1'b0));
					prev_row = held_row;
					held_row = row;
					held_count = 2'd2;
					if (last_row) begin
						owe_word(make_word(
							life_gen(prev_row & mask, held_row, '0, mask), 1'b1, 1'b1));
						prev_row = '0;
						held_row = '0;
						held_count = 2'd0;
					end
				end
			end

			if (cfg_we)
				width_reg <= cfg_data;
			words_owed <= owed_words.size();
		end
	end

endmodule

@@ tb/sv/life_generation_row_engine_unit_tb.sv @@
module life_generation_row_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lge_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int WORDS_PER_PHASE = 62;

	typedef enum int {
		FLOW_FREE,
		FLOW_SRC_IDLE,
		FLOW_SNK_STALL,
		FLOW_BOTH
	} flow_mode_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [GW_W-1:0]  cfg_data = '0;
	logic             row_valid = 1'b0;
	logic             row_stall;
	logic [ROW_W-1:0] row_cells = '0;
	logic             last_row = 1'b0;
	logic             next_valid;
	logic             next_stall = 1'b0;
	logic [ROW_W-1:0] next_cells;
	logic             last_in_run;
	logic             frame_end;

	int mismatch_count;
	int words_owed;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	life_generation_row_engine_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.row_valid   (row_valid),
		.row_stall   (row_stall),
		.row_cells   (row_cells),
		.last_row    (last_row),
		.next_valid  (next_valid),
		.next_stall  (next_stall),
		.next_cells  (next_cells),
		.last_in_run (last_in_run),
		.frame_end   (frame_end)
	);

	lge_next_row_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.row_valid      (row_valid),
		.row_stall      (row_stall),
		.row_cells      (row_cells),
		.last_row       (last_row),
		.next_valid     (next_valid),
		.next_stall     (next_stall),
		.next_cells     (next_cells),
		.last_in_run    (last_in_run),
		.frame_end      (frame_end),
		.mismatch_count (mismatch_count),
		.words_owed     (words_owed)
	);

	// random backpressure on the result side
	always @(posedge clk)
		next_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

	// watchdog: cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((row_valid && !row_stall) || (next_valid && !next_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic set_flow(input flow_mode_t mode);
		case (mode)
			FLOW_FREE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			FLOW_SRC_IDLE: begin
				idle_pct = 46;
				stall_pct = 0;
			end
			FLOW_SNK_STALL: begin
				idle_pct = 0;
				stall_pct = 46;
			end
			default: begin
				idle_pct = 35;
				stall_pct = 35;
			end
		endcase
	endtask

	// present one row and hold it until accepted
	task automatic send_row(input logic [ROW_W-1:0] cells, input logic bottom);
		while ($urandom_range(99) < idle_pct) begin
			row_valid <= 1'b0;
			@(posedge clk);
		end
		row_valid <= 1'b1;
		row_cells <= cells;
		last_row <= bottom;
		do
			@(posedge clk);
		while (!(row_valid && !row_stall));
	endtask

	function automatic logic [ROW_W-1:0] rand_row();
		logic [ROW_W-1:0] a;
		logic [ROW_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(3))
			0: return a;
			1: return a & b & {$urandom, $urandom};
			2: return a | b;
			default: return ROW_W'($urandom_range(255)) << $urandom_range(ROW_W - 1);
		endcase
	endfunction

	// whole frames of random rows, always closed by a bottom row
	task automatic random_frames(input int n_rows);
		int sent;
		int depth;
		sent = 0;
		while (sent < n_rows) begin
			depth = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 10);
			for (int r = 0; r < depth; r++)
				send_row(rand_row(), r == depth - 1);
			sent += depth;
		end
	endtask

	// let the block drain before touching the register; the owed count
	// is a registered copy of the checker's queue size
	task automatic drain();
		row_valid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [GW_W-1:0] w);
		cfg_we <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic directed_rows();
		// single-row grids
		send_row('1, 1'b1);
		send_row({32{2'b01}}, 1'b1);
		// all alive, three rows
		send_row('1, 1'b0);
		send_row('1, 1'b0);
		send_row('1, 1'b1);
		// edge columns 0 and 63
		send_row(64'h8000_0000_0000_0001, 1'b0);
		send_row(64'hC000_0000_0000_0003, 1'b1);
		// vertical blinker
		send_row('0, 1'b0);
		send_row(64'h2, 1'b0);
		send_row(64'h2, 1'b0);
		send_row(64'h2, 1'b0);
		send_row('0, 1'b1);
		// empty two-row grid
		send_row('0, 1'b0);
		send_row('0, 1'b1);
		// checkerboard
		send_row({32{2'b10}}, 1'b0);
		send_row({32{2'b01}}, 1'b0);
		send_row({32{2'b10}}, 1'b1);
		// glider
		send_row(64'h2, 1'b0);
		send_row(64'h4, 1'b0);
		send_row(64'h7, 1'b0);
		send_row('0, 1'b1);
	endtask

	initial begin
		logic [GW_W-1:0] widths[8];
		widths[0] = GRID_WIDTH_RST;
		widths[1] = '0;
		widths[2] = GW_W'(1);
		widths[3] = '1;
		widths[4] = GW_W'(3);
		widths[5] = GW_W'($urandom_range(2, 63));
		widths[6] = GW_W'($urandom_range(65, 126));
		widths[7] = GW_W'(MAX_WIDTH_DEF);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first phase runs on the reset width
		set_flow(FLOW_FREE);
		directed_rows();
		random_frames(WORDS_PER_PHASE);
		drain();

		for (int p = 1; p < 8; p++) begin
			write_width(widths[p]);
			set_flow(flow_mode_t'(p % 4));
			random_frames(WORDS_PER_PHASE);
			drain();
		end

		if (mismatch_count == 0 && words_owed == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
